### rtl/core/bayer8_ordered_dither_rgb_defines.svh
// ----------------------------------------------------------------------------
// bayer8_ordered_dither_rgb assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BAYER8_ORDERED_DITHER_RGB_DEFINES_SVH
`define BAYER8_ORDERED_DITHER_RGB_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BOD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bod assertion failed");
// next-cycle implication
`define BOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bod assertion failed");
`else
`define BOD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/bod_pkg.sv
// ----------------------------------------------------------------------------
// bod_pkg
// Types, constants and the 8x8 Bayer threshold table of the dither block.
// ----------------------------------------------------------------------------
package bod_pkg;

  localparam int unsigned MaxWidthDefault = 4096;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned StrengthW = 8;
  localparam int unsigned WidthW    = 13;
  localparam int unsigned MagW      = 14;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [CfgIdxW-1:0] CfgStrength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth    = 2'd1;

  localparam logic [StrengthW-1:0] StrengthReset = 8'd18;
  localparam logic [WidthW-1:0]    WidthReset    = 13'd240;

  localparam logic [5:0] BayerTab [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  typedef struct packed {
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] red_in;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] red_out;
  } result_t;

  // unrounded offset: sign and |2t-63| * strength
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } offs_t;

endpackage

### rtl/core/bod_scan.sv
// ----------------------------------------------------------------------------
// bod_scan
// Raster position counters and threshold product for the current pixel.
// ----------------------------------------------------------------------------
module bod_scan #(
  parameter int unsigned MaxWidth = bod_pkg::MaxWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [bod_pkg::StrengthW-1:0]  strength_i,
  input  logic [bod_pkg::WidthW-1:0]     image_width_i,
  output bod_pkg::offs_t                 offs_o
);

  localparam int unsigned CntW  = $clog2(MaxWidth);
  localparam int unsigned WideW = (CntW + 1 > bod_pkg::WidthW) ? CntW + 1 : bod_pkg::WidthW;

  logic [CntW-1:0]  col_q, col_d;
  logic [2:0]       row_q, row_d;
  logic [WideW-1:0] max_ext, width_ext, eff_width, col_inc;
  logic             wrap;
  logic [5:0]       thr;
  logic [6:0]       dbl, amp;

  always_comb begin
    max_ext   = WideW'(MaxWidth);
    width_ext = WideW'(image_width_i);
    eff_width = (width_ext == '0 || width_ext > max_ext) ? max_ext : width_ext;
    col_inc   = WideW'(col_q) + WideW'(1);
    wrap      = (col_inc >= eff_width);
    col_d     = wrap ? '0 : col_inc[CntW-1:0];
    row_d     = wrap ? row_q + 3'd1 : row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    thr        = bod_pkg::BayerTab[{row_q, col_q[2:0]}];
    dbl        = {thr, 1'b0};
    offs_o.neg = ~thr[5];
    amp        = thr[5] ? dbl - 7'd63 : 7'd63 - dbl;
    offs_o.mag = {8'b0, amp[5:0]} * {6'b0, strength_i};
  end

endmodule

### rtl/core/bod_apply.sv
// ----------------------------------------------------------------------------
// bod_apply
// Rounds the offset (divide by 126, halves away from zero) and adds it to
// each channel with saturation.
// ----------------------------------------------------------------------------
module bod_apply (
  input  bod_pkg::pixel_t  pix_i,
  input  bod_pkg::offs_t   offs_i,
  output bod_pkg::result_t res_o
);

  logic [13:0] num;
  logic [12:0] half;
  logic [22:0] prod;
  logic [6:0]  q_est;
  logic [12:0] rem;
  logic [7:0]  q;

  function automatic logic [7:0] sat_chan(input logic [7:0] ch, input logic [7:0] off,
                                          input logic neg);
    logic [8:0] sum;
    begin
      sum = {1'b0, ch} + {1'b0, off};
      if (neg) begin
        sat_chan = (ch < off) ? 8'd0 : ch - off;
      end else begin
        sat_chan = sum[8] ? 8'd255 : sum[7:0];
      end
    end
  endfunction

  // floor((mag+63)/126) = floor(floor((mag+63)/2)/63); 1040/65536 undershoots 1/63
  // by at most one step, fixed by one remainder compare
  always_comb begin
    num   = offs_i.mag + 14'd63;
    half  = num[13:1];
    prod  = {half, 10'b0} + {6'b0, half, 4'b0};
    q_est = prod[22:16];
    rem   = half - ({q_est, 6'b0} - {6'b0, q_est});
    q     = (rem >= 13'd63) ? {1'b0, q_est} + 8'd1 : {1'b0, q_est};
    res_o.blue_out  = sat_chan(pix_i.blue_in,  q, offs_i.neg);
    res_o.green_out = sat_chan(pix_i.green_in, q, offs_i.neg);
    res_o.red_out   = sat_chan(pix_i.red_in,   q, offs_i.neg);
  end

endmodule

### rtl/core/bayer8_ordered_dither_rgb.sv
// ----------------------------------------------------------------------------
// bayer8_ordered_dither_rgb
// 8x8 Bayer ordered dither on a raster stream of 8-bit BGR pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns
// one dithered pixel per request. The input stage registers the pixel with
// the threshold product for its raster position; the result stage rounds
// the offset, adds it to all three channels with saturation and holds the
// result until taken. An empty input stage loads even while the result
// stage is held. Column count wraps at image_width (0 or above MaxWidth
// means MaxWidth); the row phase steps at each wrap. The user must write
// registers only while the stream is idle; the block does not enforce it.
module bayer8_ordered_dither_rgb #(
  parameter int unsigned MaxWidth = bod_pkg::MaxWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bod_pkg::pixel_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bod_pkg::result_t              out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bod_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bod_pkg::CfgDataW-1:0]  cfg_data_i
);

  `include "bayer8_ordered_dither_rgb_defines.svh"

  logic [bod_pkg::StrengthW-1:0] strength_q;
  logic [bod_pkg::WidthW-1:0]    width_q;

  logic             s1_valid_q, out_valid_q;
  bod_pkg::pixel_t  s1_pix_q;
  bod_pkg::offs_t   s1_offs_q, scan_offs;
  bod_pkg::result_t out_data_q, apply_res;
  logic             in_fire, s1_fire, out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= bod_pkg::StrengthReset;
      width_q    <= bod_pkg::WidthReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bod_pkg::CfgStrength: strength_q <= cfg_data_i[bod_pkg::StrengthW-1:0];
        bod_pkg::CfgWidth:    width_q    <= cfg_data_i[bod_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  bod_scan #(
    .MaxWidth(MaxWidth)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_fire),
    .strength_i    (strength_q),
    .image_width_i (width_q),
    .offs_o        (scan_offs)
  );

  bod_apply u_apply (
    .pix_i  (s1_pix_q),
    .offs_i (s1_offs_q),
    .res_o  (apply_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= in_data_i;
      s1_offs_q <= scan_offs;
    end
    if (s1_fire) begin
      out_data_q <= apply_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BOD_ASSERT_NEXT(a_in_to_s1, clk_i, rst_ni, in_fire, s1_valid_q)
  `BOD_ASSERT_NEXT(a_s1_to_out, clk_i, rst_ni, s1_fire, out_valid_q)
  `BOD_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !out_free, s1_valid_q && $stable(s1_pix_q))
  `BOD_ASSERT_NEXT(a_zero_pass, clk_i, rst_ni, s1_fire && s1_offs_q.mag == '0, out_data_o == $past(s1_pix_q))
  `BOD_ASSERT_NOW(a_mag_range, clk_i, rst_ni, s1_valid_q, s1_offs_q.mag <= 14'd16065)

endmodule

### bench/bayer8_ordered_dither_rgb_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer8_ordered_dither_rgb_tb
// Self-checking bench for the 8x8 ordered dither block. Pixels are streamed
// in random bursts against a stalling output. A behavioural model of the
// raster position, threshold offset, rounding and saturation predicts every
// result. Covers register extremes, width wrap cases and back-pressure.
// ----------------------------------------------------------------------------
module bayer8_ordered_dither_rgb_tb;

  localparam int unsigned MaxW    = 4096;
  localparam int unsigned PipeLat = 2;
  localparam logic [bod_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [bod_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef enum int {RxFree, RxCoin, RxMostly, RxPeriodic} rx_mode_e;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  bod_pkg::pixel_t              in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  bod_pkg::result_t             out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bod_pkg::CfgIdxW-1:0]  cfg_index = bod_pkg::CfgStrength;
  logic [bod_pkg::CfgDataW-1:0] cfg_data  = '0;

  // predictor state
  logic [11:0]                   col_pos      = '0;
  logic [2:0]                    row_pos      = '0;
  logic [bod_pkg::StrengthW-1:0] strength_reg = bod_pkg::StrengthReset;
  logic [bod_pkg::WidthW-1:0]    width_reg    = bod_pkg::WidthReset;
  bod_pkg::result_t              dithered_q[$];
  int unsigned                   mismatches   = 0;

  // stimulus pacing
  bit          tx_gaps    = 1'b1;
  int unsigned burst_left = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  int unsigned rx_tick    = 0;
  rx_mode_e    rx_mode    = RxFree;

  bayer8_ordered_dither_rgb #(
    .MaxWidth(MaxW)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] sat_chan(logic [7:0] c, int off);
    int v;
    v = int'(c) + off;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic bod_pkg::result_t dither_predict(bod_pkg::pixel_t px);
    int               thr;
    int               num;
    int               mag;
    int               off;
    int               eff_w;
    bod_pkg::result_t r;
    thr   = int'(bod_pkg::BayerTab[{row_pos, col_pos[2:0]}]);
    num   = (2 * thr - 63) * int'(strength_reg);
    mag   = (num < 0) ? -num : num;
    off   = (mag + 63) / 126;
    if (num < 0) off = -off;
    r.blue_out  = sat_chan(px.blue_in, off);
    r.green_out = sat_chan(px.green_in, off);
    r.red_out   = sat_chan(px.red_in, off);
    eff_w = (width_reg == 0 || int'(width_reg) > MaxW) ? MaxW : int'(width_reg);
    if (int'(col_pos) + 1 >= eff_w) begin
      col_pos = '0;
      row_pos = row_pos + 3'd1;
    end else begin
      col_pos = col_pos + 12'd1;
    end
    return r;
  endfunction

  function automatic void check_chan(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    bod_pkg::result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bod_pkg::CfgStrength: strength_reg = cfg_data[bod_pkg::StrengthW-1:0];
          bod_pkg::CfgWidth:    width_reg    = cfg_data[bod_pkg::WidthW-1:0];
          default:              ;
        endcase
      end
      if (in_valid && in_ready) dithered_q.push_back(dither_predict(in_data));
      if (out_valid && out_ready) begin
        if (dithered_q.size() == 0) begin
          $error("result %h with no request outstanding", out_data);
          mismatches++;
        end else begin
          want = dithered_q.pop_front();
          check_chan("blue_out", want.blue_out, out_data.blue_out);
          check_chan("green_out", want.green_out, out_data.green_out);
          check_chan("red_out", want.red_out, out_data.red_out);
        end
      end
    end
  end

  // output stall pattern, with a long hold-off on demand
  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (rx_mode)
        RxFree:   out_ready <= 1'b1;
        RxCoin:   out_ready <= ($urandom_range(0, 1) == 1);
        RxMostly: out_ready <= ($urandom_range(0, 9) != 0);
        default:  out_ready <= ((rx_tick % 5) != 0);
      endcase
    end
  end

  task automatic send_pixel(input bod_pkg::pixel_t px);
    int unsigned gap;
    if (tx_gaps && burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dithered_q.size() != 0) @(posedge clk);
    repeat (2 * PipeLat) @(posedge clk);
  endtask

  task automatic set_reg(input logic [bod_pkg::CfgIdxW-1:0] idx,
                         input logic [bod_pkg::CfgDataW-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 12));
      3:       return 8'($urandom_range(243, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bod_pkg::pixel_t random_pixel();
    bod_pkg::pixel_t p;
    p.blue_in  = rand_chan();
    p.green_in = rand_chan();
    p.red_in   = rand_chan();
    return p;
  endfunction

  task automatic send_random(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_pixel(random_pixel());
  endtask

  task automatic test_directed();
    int unsigned k;
    // reset settings first
    send_pixel(bod_pkg::pixel_t'{8'd0, 8'd0, 8'd0});
    send_pixel(bod_pkg::pixel_t'{8'd255, 8'd255, 8'd255});
    send_pixel(bod_pkg::pixel_t'{8'd0, 8'd255, 8'd128});
    send_pixel(bod_pkg::pixel_t'{8'd255, 8'd1, 8'd254});
    send_pixel(bod_pkg::pixel_t'{8'd5, 8'd250, 8'd127});
    set_reg(bod_pkg::CfgStrength, 13'd255);
    set_reg(bod_pkg::CfgWidth, 13'd8);
    for (k = 0; k < 8; k++) send_pixel(bod_pkg::pixel_t'{8'd0, 8'd128, 8'd255});
    for (k = 0; k < 4; k++) send_pixel(bod_pkg::pixel_t'{8'd255, 8'd0, 8'd64});
    set_reg(bod_pkg::CfgStrength, 13'd1);
    for (k = 0; k < 4; k++) send_pixel(bod_pkg::pixel_t'{8'd0, 8'd255, 8'd1});
    wait_idle();
  endtask

  task automatic test_passthrough();
    set_reg(bod_pkg::CfgStrength, 13'h100);
    send_random(20);
    set_reg(bod_pkg::CfgStrength, 13'h000);
    send_random(12);
    wait_idle();
  endtask

  task automatic test_row_advance();
    set_reg(bod_pkg::CfgStrength, 13'd200);
    set_reg(bod_pkg::CfgWidth, 13'd1);
    send_random(20);
    set_reg(bod_pkg::CfgWidth, 13'd3);
    send_random(26);
    wait_idle();
  endtask

  task automatic test_width_shrink();
    set_reg(bod_pkg::CfgStrength, 13'd160);
    set_reg(bod_pkg::CfgWidth, 13'd100);
    send_random(50);
    // counter already past the new width
    set_reg(bod_pkg::CfgWidth, 13'd20);
    send_random(30);
    // counter exactly at the new width
    set_reg(bod_pkg::CfgWidth, 13'd9);
    send_random(20);
    wait_idle();
  endtask

  task automatic test_unknown_index();
    set_reg(bod_pkg::CfgWidth, 13'd13);
    send_random(7);
    set_reg(CfgSpareA, 13'h1FFF);
    set_reg(CfgSpareB, 13'h0AAA);
    send_random(20);
    set_reg(CfgSpareB, 13'h1555);
    set_reg(CfgSpareA, 13'h0000);
    send_random(20);
    wait_idle();
  endtask

  task automatic test_output_hold();
    set_reg(bod_pkg::CfgStrength, 13'd90);
    set_reg(bod_pkg::CfgWidth, 13'd17);
    hold_req = 300;
    send_random(60);
    wait_idle();
  endtask

  task automatic test_drain_pause();
    int unsigned k;
    for (k = 0; k < 4; k++) begin
      send_random($urandom_range(5, 30));
      wait_idle();
    end
  endtask

  task automatic test_max_width();
    tx_gaps = 1'b0;
    set_reg(bod_pkg::CfgStrength, 13'd77);
    set_reg(bod_pkg::CfgWidth, 13'd0);
    send_random(40);
    set_reg(bod_pkg::CfgWidth, 13'h1FFF);
    send_random(40);
    set_reg(bod_pkg::CfgWidth, 13'd4097);
    send_random(20);
    set_reg(bod_pkg::CfgWidth, 13'd4096);
    send_random(20);
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned n;
    logic [bod_pkg::CfgDataW-1:0] w;
    sent = 0;
    while (sent < 700) begin
      set_reg(bod_pkg::CfgStrength, bod_pkg::CfgDataW'($urandom));
      case ($urandom_range(0, 19))
        0:       w = 13'd1;
        1, 2, 3: w = bod_pkg::CfgDataW'($urandom_range(41, 700));
        default: w = bod_pkg::CfgDataW'($urandom_range(1, 40));
      endcase
      set_reg(bod_pkg::CfgWidth, w);
      if ($urandom_range(0, 7) == 0) set_reg(CfgSpareA, bod_pkg::CfgDataW'($urandom));
      if ($urandom_range(0, 7) == 0) set_reg(CfgSpareB, bod_pkg::CfgDataW'($urandom));
      tx_gaps = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 150);
      send_random(n);
      sent += n;
    end
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  initial begin
    int unsigned spin;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_passthrough();
    test_row_advance();
    test_width_shrink();
    test_unknown_index();
    test_output_hold();
    test_drain_pause();
    test_max_width();
    test_random();
    spin = 0;
    while (dithered_q.size() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (4 * PipeLat) @(posedge clk);
    if (dithered_q.size() != 0) begin
      $error("%0d requests never produced a result", dithered_q.size());
      mismatches++;
    end
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
